// ===== src/tvsp_pkg.sv =====
package tvsp_pkg;

    localparam int MAX_ANGLE         = 270;
    localparam int STEPS_PER_QUARTER = 500;
    localparam int FIXED_SETPOINT    = 27;
    localparam int STEP_LIMIT        = 2047;

    // target numerator: (sp*4095 - adc*292)*54, divided by 4095 afterwards
    localparam longint SP_GAIN    = 4095 * 54;
    localparam longint ADC_GAIN   = 292 * 54;
    localparam longint CLAMP_NUM  = (MAX_ANGLE + 1) * 4095;
    localparam int     DIV_SHIFT  = 33;
    localparam longint RECIP_4095 = ((64'd1 << DIV_SHIFT) + 4094) / 4095;
    localparam longint RECIP_90   = ((64'd1 << 32) + 89) / 90;

    localparam int ANGLE_W = 9;
    localparam int STEPS_W = 11;
    localparam int NUM_W   = 27;
    localparam int PROD_W  = 21;

    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_ECHO   = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [1:0] REG_USER_SETPOINT = 2'd0;
    localparam logic [1:0] REG_USE_USER      = 2'd1;
    localparam logic [1:0] REG_DOOR_TICKS    = 2'd2;

    typedef enum logic [2:0] {
        K_SAMPLE_USER,
        K_SAMPLE_FIXED,
        K_ECHO,
        K_TICK,
        K_NONE
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [6:0]  setpoint;
        logic [11:0] adc;
        logic [31:0] cap;
    } item_t;

    typedef struct packed {
        logic [3:0]         coil;
        logic               stepped;
        logic [ANGLE_W-1:0] position;
        logic [STEPS_W-1:0] steps;
        logic               door;
        logic               ignored;
    } res_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NUM,
        B_DIV,
        B_MOVE,
        B_STEPS
    } bstate_t;

endpackage

// ===== src/tvsp_front.sv =====
module tvsp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          func,
    input  logic [11:0]         adc_sample,
    input  logic [31:0]         capture_time,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic [31:0]         door_ticks,
    output logic                item_valid,
    input  logic                item_pop,
    output tvsp_pkg::item_t     item
);

    logic [6:0]           setpoint_reg;
    logic                 use_user_reg;
    logic [31:0]          door_ticks_reg;
    tvsp_pkg::item_t      slot_reg [2];
    logic [1:0]           count_reg;
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    tvsp_pkg::item_t      incoming;
    logic                 do_push;

    always_comb
    begin
        incoming.adc      = adc_sample;
        incoming.cap      = capture_time;
        incoming.setpoint = use_user_reg ? setpoint_reg : 7'(tvsp_pkg::FIXED_SETPOINT);
        unique case (func)
            tvsp_pkg::FUNC_SAMPLE:
                incoming.kind = use_user_reg ? tvsp_pkg::K_SAMPLE_USER
                                             : tvsp_pkg::K_SAMPLE_FIXED;
            tvsp_pkg::FUNC_ECHO: incoming.kind = tvsp_pkg::K_ECHO;
            tvsp_pkg::FUNC_TICK: incoming.kind = tvsp_pkg::K_TICK;
            default:             incoming.kind = tvsp_pkg::K_NONE;
        endcase
    end

    assign full       = (count_reg == 2'd2);
    assign do_push    = push && !full;
    assign item_valid = (count_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];
    assign door_ticks = door_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg   <= 7'(tvsp_pkg::FIXED_SETPOINT);
            use_user_reg   <= 1'b0;
            door_ticks_reg <= 32'd589;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tvsp_pkg::REG_USER_SETPOINT: setpoint_reg   <= cfg_data[6:0];
                tvsp_pkg::REG_USE_USER:      use_user_reg   <= cfg_data[0];
                tvsp_pkg::REG_DOOR_TICKS:    door_ticks_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (item_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(item_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= incoming;
    end

endmodule

// ===== src/tvsp_back.sv =====
module tvsp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_pop,
    input  tvsp_pkg::item_t     item,
    input  logic [31:0]         door_ticks,
    input  logic                res_ready,
    output logic                res_push,
    output tvsp_pkg::res_t      res
);

    tvsp_pkg::bstate_t                  state_reg, state_next;
    logic [1:0]                         phase_reg, phase_next;
    logic [tvsp_pkg::ANGLE_W-1:0]       position_reg, position_next;
    logic [tvsp_pkg::STEPS_W-1:0]       pending_reg, pending_next;
    logic                               reverse_reg, reverse_next;
    logic                               rising_seen_reg, rising_seen_next;
    logic [31:0]                        rising_time_reg, rising_time_next;
    logic [31:0]                        pulse_reg, pulse_next;
    logic [6:0]                         sp_reg, sp_next;
    logic [11:0]                        adc_reg, adc_next;
    logic [tvsp_pkg::NUM_W-1:0]         num_reg, num_next;
    logic [tvsp_pkg::ANGLE_W-1:0]       target_reg, target_next;
    logic [tvsp_pkg::PROD_W-1:0]        prod_reg, prod_next;

    logic [tvsp_pkg::NUM_W-1:0]         sp_term, adc_term;
    logic [42:0]                        quot_prod;
    logic [46:0]                        step_prod;
    logic [tvsp_pkg::ANGLE_W-1:0]       delta;
    logic                               door_now;
    logic [3:0]                         coil;
    logic                               stepped;
    logic                               ignored;

    assign sp_term   = tvsp_pkg::NUM_W'(sp_reg) * tvsp_pkg::NUM_W'(tvsp_pkg::SP_GAIN);
    assign adc_term  = tvsp_pkg::NUM_W'(adc_reg) * tvsp_pkg::NUM_W'(tvsp_pkg::ADC_GAIN);
    assign quot_prod = 43'(num_reg[20:0]) * 43'(tvsp_pkg::RECIP_4095);
    assign step_prod = 47'(prod_reg) * 47'(tvsp_pkg::RECIP_90);
    assign delta     = (target_reg > position_reg) ? target_reg - position_reg
                                                   : position_reg - target_reg;
    assign door_now  = (pulse_reg >= door_ticks);

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        position_next    = position_reg;
        pending_next     = pending_reg;
        reverse_next     = reverse_reg;
        rising_seen_next = rising_seen_reg;
        rising_time_next = rising_time_reg;
        pulse_next       = pulse_reg;
        sp_next          = sp_reg;
        adc_next         = adc_reg;
        num_next         = num_reg;
        target_next      = target_reg;
        prod_next        = prod_reg;
        item_pop         = 1'b0;
        res_push         = 1'b0;
        coil             = 4'd0;
        stepped          = 1'b0;
        ignored          = 1'b0;

        unique case (state_reg)
            tvsp_pkg::B_IDLE:
            begin
                // take a word only when its result has a slot waiting
                if (item_valid && res_ready)
                begin
                    item_pop = 1'b1;
                    unique case (item.kind)
                        tvsp_pkg::K_SAMPLE_USER, tvsp_pkg::K_SAMPLE_FIXED:
                        begin
                            if (pending_reg != '0)
                            begin
                                ignored  = 1'b1;
                                res_push = 1'b1;
                            end
                            else if (item.kind == tvsp_pkg::K_SAMPLE_FIXED && !door_now)
                            begin
                                target_next = '0;
                                state_next  = tvsp_pkg::B_MOVE;
                            end
                            else
                            begin
                                sp_next    = item.setpoint;
                                adc_next   = item.adc;
                                state_next = tvsp_pkg::B_NUM;
                            end
                        end
                        tvsp_pkg::K_ECHO:
                        begin
                            res_push = 1'b1;
                            if (!rising_seen_reg)
                            begin
                                rising_time_next = item.cap;
                                rising_seen_next = 1'b1;
                            end
                            else
                            begin
                                // wrap rule: equal times give all ones
                                if (item.cap > rising_time_reg)
                                    pulse_next = item.cap - rising_time_reg;
                                else
                                    pulse_next = ~rising_time_reg + item.cap;
                                rising_seen_next = 1'b0;
                            end
                        end
                        tvsp_pkg::K_TICK:
                        begin
                            res_push = 1'b1;
                            if (pending_reg != '0)
                            begin
                                coil         = 4'b0001 << phase_reg;
                                stepped      = 1'b1;
                                phase_next   = reverse_reg ? phase_reg - 2'd1
                                                           : phase_reg + 2'd1;
                                pending_next = pending_reg - tvsp_pkg::STEPS_W'(1);
                            end
                        end
                        default:
                            res_push = 1'b1;
                    endcase
                end
            end
            tvsp_pkg::B_NUM:
            begin
                num_next   = sp_term - adc_term;
                state_next = tvsp_pkg::B_DIV;
            end
            tvsp_pkg::B_DIV:
            begin
                // clamp negative and oversized numerators before the reciprocal
                if (num_reg[tvsp_pkg::NUM_W-1] || num_reg == '0)
                    target_next = '0;
                else if (num_reg >= tvsp_pkg::NUM_W'(tvsp_pkg::CLAMP_NUM))
                    target_next = tvsp_pkg::ANGLE_W'(tvsp_pkg::MAX_ANGLE);
                else
                    target_next = quot_prod[tvsp_pkg::DIV_SHIFT +: tvsp_pkg::ANGLE_W];
                state_next = tvsp_pkg::B_MOVE;
            end
            tvsp_pkg::B_MOVE:
            begin
                if (target_reg == position_reg)
                begin
                    res_push   = 1'b1;
                    state_next = tvsp_pkg::B_IDLE;
                end
                else
                begin
                    reverse_next = (target_reg < position_reg);
                    prod_next    = tvsp_pkg::PROD_W'(delta)
                                 * tvsp_pkg::PROD_W'(tvsp_pkg::STEPS_PER_QUARTER);
                    state_next   = tvsp_pkg::B_STEPS;
                end
            end
            tvsp_pkg::B_STEPS:
            begin
                if (step_prod[46:43] != 4'd0)
                    pending_next = tvsp_pkg::STEPS_W'(tvsp_pkg::STEP_LIMIT);
                else
                    pending_next = step_prod[42:32];
                position_next = target_reg;
                res_push      = 1'b1;
                state_next    = tvsp_pkg::B_IDLE;
            end
            default:
                state_next = tvsp_pkg::B_IDLE;
        endcase

        res.coil     = coil;
        res.stepped  = stepped;
        res.position = position_next;
        res.steps    = pending_next;
        res.door     = (pulse_next >= door_ticks);
        res.ignored  = ignored;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tvsp_pkg::B_IDLE;
            phase_reg       <= 2'd0;
            position_reg    <= '0;
            pending_reg     <= '0;
            reverse_reg     <= 1'b0;
            rising_seen_reg <= 1'b0;
            pulse_reg       <= 32'd0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            position_reg    <= position_next;
            pending_reg     <= pending_next;
            reverse_reg     <= reverse_next;
            rising_seen_reg <= rising_seen_next;
            pulse_reg       <= pulse_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rising_time_reg <= rising_time_next;
        sp_reg          <= sp_next;
        adc_reg         <= adc_next;
        num_reg         <= num_next;
        target_reg      <= target_next;
        prod_reg        <= prod_next;
    end

endmodule

// ===== src/tvsp_resq.sv =====
module tvsp_resq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_push,
    input  tvsp_pkg::res_t      res_in,
    output logic                res_ready,
    output logic                empty,
    input  logic                pop,
    output tvsp_pkg::res_t      res_out
);

    tvsp_pkg::res_t slot_reg [2];
    logic [1:0]     count_reg;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic           do_pop;

    assign res_ready = (count_reg != 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign do_pop    = pop && !empty;
    assign res_out   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (res_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(res_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            slot_reg[wr_ptr_reg] <= res_in;
    end

endmodule

// ===== src/thermal_vent_stepper_positioner_core.sv =====
// channel   direction  handshake                      word
// input     in         push / full                    func, adc_sample, capture_time
// result    out        pop / empty                    coil_pattern .. sample_ignored
// config    in         cfg_write (no wait)            cfg_index, cfg_data
//
// Ticks, echo edges, unused kinds and ignored samples are answered on acceptance once
// out of the two-word input queue; a sample that computes an angle runs accept,
// numerator, divide by 4095, delta, step count and update, stopping at delta if nothing
// moves. A closed-door fixed-mode sample skips to delta, stopping there if at zero.
// Reset empties both queues. The back end takes a word only when the two-word result
// queue has room, so a stalled consumer holds it while the front still buffers input.
module thermal_vent_stepper_positioner_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  func,
    input  logic [11:0] adc_sample,
    input  logic [31:0] capture_time,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  coil_pattern,
    output logic        stepped,
    output logic [8:0]  position_deg,
    output logic [10:0] steps_remaining,
    output logic        door_open,
    output logic        sample_ignored,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic             item_valid;
    logic             item_pop;
    tvsp_pkg::item_t  item;
    logic [31:0]      door_ticks;
    logic             res_ready;
    logic             res_push;
    tvsp_pkg::res_t   res_in;
    tvsp_pkg::res_t   res_out;

    tvsp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .adc_sample   (adc_sample),
        .capture_time (capture_time),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .door_ticks   (door_ticks),
        .item_valid   (item_valid),
        .item_pop     (item_pop),
        .item         (item)
    );

    tvsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item),
        .door_ticks (door_ticks),
        .res_ready  (res_ready),
        .res_push   (res_push),
        .res        (res_in)
    );

    tvsp_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res_in    (res_in),
        .res_ready (res_ready),
        .empty     (empty),
        .pop       (pop),
        .res_out   (res_out)
    );

    assign coil_pattern    = res_out.coil;
    assign stepped         = res_out.stepped;
    assign position_deg    = res_out.position;
    assign steps_remaining = res_out.steps;
    assign door_open       = res_out.door;
    assign sample_ignored  = res_out.ignored;

endmodule
